@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL top level, chacha20_keystream_rng_unit.
// Depends on nothing; bodies vanish under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/ccrng_pkg.sv @@
// Shared constants and functions for the ChaCha keystream generator.
// No dependencies.
package ccrng_pkg;
  localparam int DOUBLE_ROUNDS = 10;
  localparam int ROUNDS = 2 * DOUBLE_ROUNDS;
  localparam logic [31:0] NONCE_XOR = 32'hAAAAAAAA;
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;
  localparam logic [1:0] MODE_WORD = 2'd0;
  localparam logic [1:0] MODE_DWORD = 2'd1;
  localparam logic [1:0] MODE_BYTES = 2'd2;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] blk_t;

  function automatic word_t rotl(input word_t v, input int s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  function automatic logic [127:0] qr(input word_t a, input word_t b,
                                     input word_t c, input word_t d);
    word_t a1, b1, c1, d1;
    a1 = a + b; d1 = rotl(d ^ a1, 16);
    c1 = c + d1; b1 = rotl(b ^ c1, 12);
    a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
    c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
    qr = {a1, b1, c1, d1};
  endfunction
endpackage

@@ rtl/ccrng_if.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on nothing.
interface ccrng_req_if;
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [6:0] byte_count;
  modport source (output valid, mode, byte_count, input ready);
  modport sink (input valid, mode, byte_count, output ready);
endinterface

interface ccrng_res_if;
  logic valid;
  logic ready;
  logic [31:0] value_high;
  logic [31:0] value_low;
  logic last;
  modport source (output valid, value_high, value_low, last, input ready);
  modport sink (input valid, value_high, value_low, last, output ready);
endinterface

@@ rtl/chacha20_keystream_rng_unit.sv @@
// ChaCha20 keystream generator top level: request control and buffer memory.
// Depends on ccrng_pkg, ccrng_if, ccrng_core, assert_macros.svh.
//
// Usage: write the 64-bit seed on cfg_we/cfg_wdata while idle; this rekeys
// and restarts the block counter. Requests arrive on the in_ channel: mode 0
// gives one word, mode 1 a 64-bit value (first word in value_high), mode 2
// byte_count bytes (saturated to 64), one result word each, last on the final.
// Mode 3 and a zero count are taken and produce nothing.
// The keystream buffer is a 16-entry synchronous RAM with registered read data,
// one word read per byte result or per 32-bit half of a result. A request that
// crosses the end of the buffer runs a block: the core's 20 rounds, then the 16
// block words written into the RAM. Word requests pass the read, data and out
// states, 64-bit twice, bytes once each; one block is amortized across 64 bytes.
// The result sits in an output register; a stalled receiver just holds the
// FSM until out_ready, nothing is lost. One request in flight at a time.
// Reset (rst_n synchronous, low) sets seed 0 and forces a refill on first use.
`include "assert_macros.svh"
module chacha20_keystream_rng_unit import ccrng_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ccrng_req_if.sink   in_ch,
  ccrng_res_if.source out_ch,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FILL = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_DATA = 3'd4;
  localparam logic [2:0] ST_OUT = 3'd5;

  logic [2:0] st_r;
  logic [63:0] seed_r, ctr_r;
  logic [6:0] pos_r;
  logic [1:0] mode_r;
  logic [6:0] left_r;
  logic half_r;
  logic [31:0] hi_r;
  logic [3:0] wa_r;
  blk_t blk_r;
  logic [31:0] mem [16];
  logic [31:0] rd_r;
  logic core_start, core_done;
  blk_t init, res;
  logic [31:0] lo, hi;
  logic [31:0] ov_hi_r, ov_lo_r;
  logic ov_last_r, ov_valid_r;
  logic [7:0] bsel;

  assign lo = seed_r[31:0];
  assign hi = seed_r[63:32];
  always_comb begin
    init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
    for (int i = 0; i < 8; i++) init[4 + i] = i[0] ? hi : lo;
    init[12] = ctr_r[31:0];
    init[13] = ctr_r[63:32];
    init[14] = hi ^ NONCE_XOR;
    init[15] = lo ^ NONCE_XOR;
  end

  ccrng_core u_core (.clk, .rst_n, .start(core_start), .init, .done(core_done),
                     .result(res));

  always_ff @(posedge clk) begin
    if (st_r == ST_WRITE) mem[wa_r] <= blk_r[wa_r];
    rd_r <= mem[pos_r[5:2]];
  end

  always_comb begin
    case (pos_r[1:0])
      2'd0: bsel = rd_r[7:0];
      2'd1: bsel = rd_r[15:8];
      2'd2: bsel = rd_r[23:16];
      default: bsel = rd_r[31:24];
    endcase
  end

  assign in_ch.ready = st_r == ST_IDLE && !ov_valid_r;
  assign core_start = st_r == ST_READ && pos_r[6];
  assign out_ch.valid = ov_valid_r;
  assign out_ch.value_high = ov_hi_r;
  assign out_ch.value_low = ov_lo_r;
  assign out_ch.last = ov_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      seed_r <= '0;
      ctr_r <= {NONCE_XOR, 32'd0};
      pos_r <= 7'd64;
      ov_valid_r <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) ov_valid_r <= 1'b0;
      if (cfg_we) begin
        seed_r <= cfg_wdata;
        ctr_r <= {cfg_wdata[31:0] ^ NONCE_XOR, 32'd0};
        pos_r <= 7'd64;
      end
      case (st_r)
        ST_IDLE: if (in_ch.valid && in_ch.ready) begin
          mode_r <= in_ch.mode;
          left_r <= in_ch.byte_count > 7'd64 ? 7'd64 : in_ch.byte_count;
          half_r <= 1'b0;
          if (in_ch.mode == MODE_WORD || in_ch.mode == MODE_DWORD ||
              (in_ch.mode == MODE_BYTES && in_ch.byte_count != 7'd0))
            st_r <= ST_READ;
        end
        ST_READ: st_r <= pos_r[6] ? ST_FILL : ST_DATA;
        ST_FILL: if (core_done) begin
          blk_r <= res;
          ctr_r <= ctr_r + 64'd1;
          wa_r <= '0;
          pos_r <= '0;
          st_r <= ST_WRITE;
        end
        ST_WRITE: begin
          wa_r <= wa_r + 4'd1;
          if (wa_r == 4'd15) st_r <= ST_READ;
        end
        ST_DATA: st_r <= ST_OUT;
        ST_OUT: if (!ov_valid_r) begin
          if (mode_r == MODE_BYTES) begin
            ov_hi_r <= '0;
            ov_lo_r <= {24'd0, bsel};
            ov_last_r <= left_r == 7'd1;
            ov_valid_r <= 1'b1;
            pos_r <= pos_r + 7'd1;
            left_r <= left_r - 7'd1;
            st_r <= left_r == 7'd1 ? ST_IDLE : ST_READ;
          end else if (mode_r == MODE_DWORD && !half_r) begin
            hi_r <= rd_r;
            half_r <= 1'b1;
            pos_r <= pos_r + 7'd4;
            st_r <= ST_READ;
          end else begin
            ov_hi_r <= mode_r == MODE_DWORD ? hi_r : 32'd0;
            ov_lo_r <= rd_r;
            ov_last_r <= 1'b1;
            ov_valid_r <= 1'b1;
            pos_r <= pos_r + 7'd4;
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_start_fill, clk, rst_n, core_start, st_r == ST_FILL)
  `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, st_r != ST_IDLE, !in_ch.ready)
  `ASSERT_IMPL(a_write_pos0, clk, rst_n, st_r == ST_WRITE, pos_r == 7'd0)
  `ASSERT_IMPL(a_out_valid_pos, clk, rst_n, st_r == ST_DATA, !pos_r[6])
endmodule

@@ rtl/ccrng_core.sv @@
// ChaCha block core: one round per cycle, then feed-forward add.
// Depends on ccrng_pkg.
module ccrng_core import ccrng_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  blk_t        init,
  output logic        done,
  output blk_t        result
);
  blk_t x_r, x_nxt;
  logic [4:0] rnd_r;
  logic busy_r;
  logic [127:0] q0, q1, q2, q3;

  always_comb begin
    x_nxt = x_r;
    if (!rnd_r[0]) begin
      q0 = qr(x_r[0], x_r[4], x_r[8], x_r[12]);
      q1 = qr(x_r[1], x_r[5], x_r[9], x_r[13]);
      q2 = qr(x_r[2], x_r[6], x_r[10], x_r[14]);
      q3 = qr(x_r[3], x_r[7], x_r[11], x_r[15]);
      {x_nxt[0], x_nxt[4], x_nxt[8], x_nxt[12]} = q0;
      {x_nxt[1], x_nxt[5], x_nxt[9], x_nxt[13]} = q1;
      {x_nxt[2], x_nxt[6], x_nxt[10], x_nxt[14]} = q2;
      {x_nxt[3], x_nxt[7], x_nxt[11], x_nxt[15]} = q3;
    end else begin
      q0 = qr(x_r[0], x_r[5], x_r[10], x_r[15]);
      q1 = qr(x_r[1], x_r[6], x_r[11], x_r[12]);
      q2 = qr(x_r[2], x_r[7], x_r[8], x_r[13]);
      q3 = qr(x_r[3], x_r[4], x_r[9], x_r[14]);
      {x_nxt[0], x_nxt[5], x_nxt[10], x_nxt[15]} = q0;
      {x_nxt[1], x_nxt[6], x_nxt[11], x_nxt[12]} = q1;
      {x_nxt[2], x_nxt[7], x_nxt[8], x_nxt[13]} = q2;
      {x_nxt[3], x_nxt[4], x_nxt[9], x_nxt[14]} = q3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      rnd_r <= '0;
    end else if (busy_r) begin
      rnd_r <= rnd_r + 5'd1;
      if (rnd_r == 5'(ROUNDS - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) x_r <= init;
    else if (busy_r) x_r <= x_nxt;
  end

  assign done = busy_r && rnd_r == 5'(ROUNDS - 1);
  always_comb begin
    for (int i = 0; i < 16; i++) result[i] = x_nxt[i] + init[i];
  end
endmodule
